/* rtl/core/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/mppt_pkg.sv */
// constants and register map of the sweep tracker
`default_nettype none
package mppt_pkg;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int DUTY_W = 9;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [DUTY_W-1:0] DUTY_START = 9'd80;
	localparam logic [DUTY_W-1:0] DUTY_END = 9'd320;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 9'd511;

	localparam logic [7:0] STEP_RST = 8'd4;
	localparam logic [4:0] DIV_RST = 5'd25;
	localparam logic [3:0] HOLD_RST = 4'd10;

	localparam logic [1:0] REG_SWEEP_STEP = 2'd0;
	localparam logic [1:0] REG_UPDATE_DIV = 2'd1;
	localparam logic [1:0] REG_RELEASE_HOLD = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/mppt_duty_sweep.sv */
// maximum power point duty sweep tracker with apb configuration
// input words are registered in stage s1, result words in the output register
// throughput: one word per cycle unless out_stall backs up; the state update
// (one multiply, a compare against best power) sits between those registers
// reset: arst_n clears the sweep state; duty to 80, registers to defaults
`default_nettype none
`include "assert_macros.svh"
module mppt_duty_sweep #(
	parameter int SAMPLE_BITS = mppt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          button_down,
	input  wire logic [SAMPLE_BITS-1:0]        current_sample,
	input  wire logic [SAMPLE_BITS-1:0]        voltage_sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [mppt_pkg::DUTY_W-1:0]        duty_cycle,
	output logic                               led_on,
	output logic                               sweep_done,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mppt_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mppt_pkg::DATA_W-1:0]   pwdata,
	output logic [mppt_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	localparam int PW = 2 * SAMPLE_BITS;
	localparam int DW = mppt_pkg::DUTY_W;

	logic [7:0] step_q;
	logic [4:0] updiv_q;
	logic [3:0] hold_lim_q;

	logic                   valid_s1;
	logic                   button_s1;
	logic [SAMPLE_BITS-1:0] cur_s1;
	logic [SAMPLE_BITS-1:0] volt_s1;

	logic          button_q;
	logic          done_q;
	logic [3:0]    hold_q;
	logic [4:0]    div_q;
	logic [DW-1:0] duty_q;
	logic [DW-1:0] best_duty_q;
	logic [PW-1:0] best_power_q;
	logic          led_q;

	logic          out_valid_q;
	logic [DW-1:0] duty_out_q;
	logic          led_out_q;
	logic          done_out_q;

	logic          adv_s1;
	logic          in_fire;
	logic          cfg_wr;

	logic          button_n;
	logic          done_n;
	logic [3:0]    hold_n;
	logic [4:0]    div_n;
	logic [DW-1:0] duty_n;
	logic [DW-1:0] best_duty_n;
	logic [PW-1:0] best_power_n;
	logic          led_n;
	logic [PW-1:0] power;
	logic [DW:0]   duty_sum;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign adv_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_fire = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign duty_cycle = duty_out_q;
	assign led_on = led_out_q;
	assign sweep_done = done_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mppt_pkg::STEP_RST;
			updiv_q <= mppt_pkg::DIV_RST;
			hold_lim_q <= mppt_pkg::HOLD_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mppt_pkg::REG_SWEEP_STEP: step_q <= pwdata[7:0];
				mppt_pkg::REG_UPDATE_DIV: updiv_q <= pwdata[4:0];
				mppt_pkg::REG_RELEASE_HOLD: hold_lim_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mppt_pkg::REG_SWEEP_STEP: prdata = {24'd0, step_q};
			mppt_pkg::REG_UPDATE_DIV: prdata = {27'd0, updiv_q};
			mppt_pkg::REG_RELEASE_HOLD: prdata = {28'd0, hold_lim_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			button_s1 <= button_down;
			cur_s1 <= current_sample;
			volt_s1 <= voltage_sample;
		end
	end

	always_comb begin
		button_n = button_q;
		done_n = done_q;
		hold_n = hold_q;
		div_n = div_q;
		duty_n = duty_q;
		best_duty_n = best_duty_q;
		best_power_n = best_power_q;
		led_n = led_q;
		power = cur_s1 * volt_s1;
		duty_sum = '0;
		if (button_s1) begin
			button_n = 1'b1;
			led_n = 1'b1;
			best_power_n = '0;
			duty_n = mppt_pkg::DUTY_START;
			hold_n = '0;
		end else if (button_q) begin
			if (hold_q >= hold_lim_q) begin
				led_n = 1'b0;
				button_n = 1'b0;
				done_n = 1'b0;
				hold_n = '0;
			end else begin
				hold_n = hold_q + 4'd1;
			end
		end
		if (!done_n) begin
			if (div_q >= updiv_q) begin
				div_n = '0;
				if (power > best_power_n) begin
					best_duty_n = duty_n;
					best_power_n = power;
				end
				if (duty_n >= mppt_pkg::DUTY_END) begin
					done_n = 1'b1;
					duty_n = best_duty_n;
				end else begin
					duty_sum = {1'b0, duty_n} + {2'b00, step_q};
					if (duty_sum > {1'b0, mppt_pkg::DUTY_MAX}) begin
						duty_n = mppt_pkg::DUTY_MAX;
					end else begin
						duty_n = duty_sum[DW-1:0];
					end
					led_n = (duty_n[3:0] == 4'd0);
				end
			end else begin
				div_n = div_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			button_q <= 1'b0;
			done_q <= 1'b0;
			hold_q <= '0;
			div_q <= '0;
			duty_q <= mppt_pkg::DUTY_START;
			best_duty_q <= '0;
			best_power_q <= '0;
			led_q <= 1'b0;
		end else if (adv_s1) begin
			button_q <= button_n;
			done_q <= done_n;
			hold_q <= hold_n;
			div_q <= div_n;
			duty_q <= duty_n;
			best_duty_q <= best_duty_n;
			best_power_q <= best_power_n;
			led_q <= led_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			duty_out_q <= duty_n;
			led_out_q <= led_n;
			done_out_q <= done_n;
		end
	end

	`ASSERT_IMPL(a_stall_full, clk, arst_n, in_stall, valid_s1 && out_valid_q)
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s1, valid_s1 && $stable(cur_s1))
	`ASSERT_IMPL(a_done_on_word, clk, arst_n, $rose(done_q), $past(adv_s1))
	`ASSERT_NEXT(a_press, clk, arst_n, adv_s1 && button_s1, button_q && hold_q == 4'd0)
	`ASSERT_NEXT(a_result, clk, arst_n, adv_s1, out_valid_q && duty_out_q == duty_q)
endmodule
`default_nettype wire

/* dv/mppt_sweep_checker.sv */
// sweep tracker checker: predicts each result word from accepted words and compares
`default_nettype none
module mppt_sweep_checker #(
	parameter int SB = mppt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic                          button_down,
	input  wire logic [SB-1:0]                 current_sample,
	input  wire logic [SB-1:0]                 voltage_sample,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [mppt_pkg::DUTY_W-1:0]   duty_cycle,
	input  wire logic                          led_on,
	input  wire logic                          sweep_done,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic                          pready,
	input  wire logic [mppt_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mppt_pkg::DATA_W-1:0]   pwdata,
	output int                                 fail_count,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LED_MODULUS = 16;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [mppt_pkg::DUTY_W-1:0] duty;
		logic                        led;
		logic                        done;
	} sweep_word_t;

	logic [7:0] step_cfg;
	logic [4:0] div_cfg;
	logic [3:0] hold_cfg;

	logic                        latched;
	logic                        done;
	logic [3:0]                  hold_cnt;
	logic [4:0]                  tick_div;
	logic [mppt_pkg::DUTY_W-1:0] duty;
	logic [mppt_pkg::DUTY_W-1:0] best_duty;
	logic [2*SB-1:0]             best_power;
	logic                        led;

	sweep_word_t pending_sweep_words[$];
	int          mismatches;

	function automatic sweep_word_t track_tick(input logic btn, input logic [SB-1:0] cur,
			input logic [SB-1:0] volt);
		logic [2*SB-1:0]           power;
		logic [mppt_pkg::DUTY_W:0] stepped;
		sweep_word_t               w;
		if (btn) begin
			latched = 1'b1;
			led = 1'b1;
			best_power = '0;
			duty = mppt_pkg::DUTY_START;
			hold_cnt = '0;
		end else if (latched) begin
			if (hold_cnt >= hold_cfg) begin
				led = 1'b0;
				latched = 1'b0;
				done = 1'b0;
				hold_cnt = '0;
			end else begin
				hold_cnt = hold_cnt + 4'd1;
			end
		end
		if (!done) begin
			if (tick_div >= div_cfg) begin
				power = cur * volt;
				tick_div = '0;
				if (power > best_power) begin
					best_duty = duty;
					best_power = power;
				end
				if (duty >= mppt_pkg::DUTY_END) begin
					done = 1'b1;
					duty = best_duty;
				end else begin
					stepped = {1'b0, duty} + {2'b00, step_cfg};
					if (stepped > {1'b0, mppt_pkg::DUTY_MAX})
						stepped = {1'b0, mppt_pkg::DUTY_MAX};
					duty = stepped[mppt_pkg::DUTY_W-1:0];
					led = (duty % LED_MODULUS) == 0;
				end
			end else begin
				tick_div = tick_div + 5'd1;
			end
		end
		w.duty = duty;
		w.led = led;
		w.done = done;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sweep_word_t exp_w;
		if (!arst_n) begin
			step_cfg = mppt_pkg::STEP_RST;
			div_cfg = mppt_pkg::DIV_RST;
			hold_cfg = mppt_pkg::HOLD_RST;
			latched = 1'b0;
			done = 1'b0;
			hold_cnt = '0;
			tick_div = '0;
			duty = mppt_pkg::DUTY_START;
			best_duty = '0;
			best_power = '0;
			led = 1'b0;
			pending_sweep_words.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_sweep_words.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected word: duty %0d led %0b done %0b",
							duty_cycle, led_on, sweep_done);
				end else begin
					exp_w = pending_sweep_words.pop_front();
					if (duty_cycle !== exp_w.duty || led_on !== exp_w.led
							|| sweep_done !== exp_w.done) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display({"word mismatch: expected duty %0d led %0b done %0b,",
								" got duty %0d led %0b done %0b"},
								exp_w.duty, exp_w.led, exp_w.done,
								duty_cycle, led_on, sweep_done);
					end
				end
			end
			if (in_valid && !in_stall)
				pending_sweep_words.push_back(track_tick(button_down, current_sample,
					voltage_sample));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					mppt_pkg::REG_SWEEP_STEP: step_cfg = pwdata[7:0];
					mppt_pkg::REG_UPDATE_DIV: div_cfg = pwdata[4:0];
					mppt_pkg::REG_RELEASE_HOLD: hold_cfg = pwdata[3:0];
					default: ;
				endcase
			end
			fail_count <= mismatches;
			pending <= pending_sweep_words.size();
		end
	end
endmodule
`default_nettype wire

/* dv/tb_mppt_duty_sweep.sv */
// testbench top for the sweep tracker: stimulus, register setup and verdict
`default_nettype none
module tb_mppt_duty_sweep;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB = mppt_pkg::SAMPLE_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        button_down = 1'b0;
	logic [SB-1:0]               current_sample = '0;
	logic [SB-1:0]               voltage_sample = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [mppt_pkg::DUTY_W-1:0] duty_cycle;
	logic                        led_on;
	logic                        sweep_done;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [mppt_pkg::ADDR_W-1:0] paddr = '0;
	logic [mppt_pkg::DATA_W-1:0] pwdata = '0;
	logic [mppt_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	int fail_count;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	mppt_duty_sweep #(.SAMPLE_BITS(SB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.button_down(button_down), .current_sample(current_sample),
		.voltage_sample(voltage_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.duty_cycle(duty_cycle), .led_on(led_on), .sweep_done(sweep_done),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mppt_sweep_checker #(.SB(SB)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.button_down(button_down), .current_sample(current_sample),
		.voltage_sample(voltage_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.duty_cycle(duty_cycle), .led_on(led_on), .sweep_done(sweep_done),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_word(input logic btn, input logic [SB-1:0] cur,
			input logic [SB-1:0] volt);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		button_down <= btn;
		current_sample <= cur;
		voltage_sample <= volt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [mppt_pkg::DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(input logic [7:0] step, input logic [4:0] div,
			input logic [3:0] hold);
		drain();
		write_reg(mppt_pkg::REG_SWEEP_STEP, {24'd0, step});
		write_reg(mppt_pkg::REG_UPDATE_DIV, {27'd0, div});
		write_reg(mppt_pkg::REG_RELEASE_HOLD, {28'd0, hold});
	endtask

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return SB'($urandom_range(2**SB - 1));
		endcase
	endfunction

	task automatic run_phase(input logic [7:0] step, input logic [4:0] div,
			input logic [3:0] hold, input int idle, input int stall, input int n);
		int sent;
		int burst;
		set_regs(step, div, hold);
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 4) begin
				burst = $urandom_range(1, 3);
				repeat (burst) send_word(1'b1, pick_sample(), pick_sample());
				sent += burst;
			end else begin
				send_word(1'b0, pick_sample(), pick_sample());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero power all the way: sweep ends at duty 0
		set_regs(8'd240, 5'd0, 4'd0);
		send_word(1'b0, 10'd0, 10'd0);
		send_word(1'b0, 10'd0, 10'd0);
		send_word(1'b0, 10'd1023, 10'd1023);
		// press while done, then release
		send_word(1'b1, 10'd1023, 10'd1023);
		send_word(1'b1, 10'd0, 10'd1023);
		send_word(1'b0, 10'd1023, 10'd0);
		send_word(1'b0, 10'd1023, 10'd1023);
		send_word(1'b0, 10'd1, 10'd1);
		send_word(1'b0, 10'd1023, 10'd1023);
		send_word(1'b0, 10'd512, 10'd512);

		// press while done under a long release hold: duty stays at 80, no step is taken
		set_regs(8'd230, 5'd0, 4'd15);
		send_word(1'b1, 10'd512, 10'd1);
		send_word(1'b0, 10'd1023, 10'd1023);
		send_word(1'b0, 10'd1, 10'd1023);
		send_word(1'b0, 10'd1023, 10'd1);
		send_word(1'b0, 10'd0, 10'd0);

		// zero step never finishes
		set_regs(8'd0, 5'd0, 4'd0);
		send_word(1'b1, 10'd300, 10'd300);
		send_word(1'b0, 10'd1023, 10'd1023);
		send_word(1'b0, 10'd2, 10'd700);
		send_word(1'b0, 10'd1023, 10'd1023);

		set_regs(8'd255, 5'd31, 4'd15);
		send_word(1'b1, 10'd1023, 10'd1023);
		send_word(1'b0, 10'd341, 10'd682);
		send_word(1'b0, 10'd682, 10'd341);

		run_phase(8'd16, 5'd0, 4'd3, 0, 0, 90);
		run_phase(8'd240, 5'd1, 4'd15, 78, 0, 70);
		run_phase(8'd8, 5'd0, 4'd0, 0, 78, 100);
		run_phase(8'd1, 5'd31, 4'd10, 7, 7, 40);
		run_phase(8'd48, 5'd3, 4'd6, 7, 7, 100);

		drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
